/* rtl/radix_digit_converter_defines.svh */
// Assertion macros shared by the radix digit converter RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdc: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define RDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdc: next-cycle check failed");

`endif

/* rtl/rdc_pkg.sv */
// Types, constants and the digit-to-ASCII function of the radix digit converter.
// No dependencies.
package rdc_pkg;

   localparam int unsigned VALUE_W     = 64;
   localparam int unsigned RADIX_W     = 5;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned CHAR_W      = 7;
   localparam int unsigned DIV_BITS    = 8;
   localparam int unsigned DIV_CYCLES  = VALUE_W / DIV_BITS;
   localparam int unsigned DIV_CNT_W   = $clog2(DIV_CYCLES);

   localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

   localparam logic [CHAR_W-1:0] LOWER_SET [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
   };
   localparam logic [CHAR_W-1:0] UPPER_SET [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] radix;
      logic               lower_letters;
   } rdc_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } rdc_rsp_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quotient;
      logic [DIGIT_W-1:0] remainder;
   } rdc_div_result_type;

   function automatic logic [CHAR_W-1:0] rdc_digit_char(input logic [DIGIT_W-1:0] digit,
                                                        input logic lower);
      if (lower) begin
         return LOWER_SET[digit];
      end
      return UPPER_SET[digit];
   endfunction

endpackage

/* rtl/rdc_divider.sv */
// Shared iterative divider: 64-bit dividend by a 2..16 divisor, 8 quotient bits a cycle.
// Depends on rdc_pkg and radix_digit_converter_defines.svh.
module rdc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rdc_pkg::VALUE_W-1:0]   dividend,
   input  logic [rdc_pkg::RADIX_W-1:0]   divisor,
   output rdc_pkg::rdc_div_result_type   result
);
   import rdc_pkg::*;

   logic [VALUE_W-1:0]   quo_ff,  quo_in;
   logic [DIGIT_W-1:0]   rem_ff,  rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                 run_ff,  run_in;
   logic                 done_ff, done_in;
   logic [VALUE_W-1:0]   step_quo;
   logic [DIGIT_W-1:0]   step_rem;

   always_comb begin
      logic [RADIX_W-1:0] partial;
      step_quo = quo_ff;
      step_rem = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         partial = {step_rem, step_quo[VALUE_W-1]};
         if (partial >= divisor) begin
            step_rem = DIGIT_W'(partial - divisor);
            step_quo = {step_quo[VALUE_W-2:0], 1'b1};
         end else begin
            step_rem = partial[DIGIT_W-1:0];
            step_quo = {step_quo[VALUE_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = step_quo;
         rem_in = step_rem;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

   `include "radix_digit_converter_defines.svh"

   `RDC_ASSERT_IMPLY(a_rem_below_divisor, clock, reset, done_ff, {1'b0, rem_ff} < divisor)
   `RDC_ASSERT_IMPLY(a_done_ends_run, clock, reset, done_ff, !run_ff || $past(start))
   `RDC_ASSERT_NEXT(a_start_runs, clock, reset, start, run_ff)

endmodule

/* rtl/radix_digit_converter.sv */
// All digits are first computed one at a time in the shared divider (shift steps and a
// handoff per digit), then emitted one per rsp_strobe pulse; busy stays high through
// the whole conversion. Throughput: one request at a time; the next request is taken
// once busy falls.
// Reset (synchronous, active high) returns to idle and clears the digit count and strobe;
// the digit store holds no reset value and is always written before it is read.
module radix_digit_converter #(
   parameter int unsigned MAX_DIGITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rdc_pkg::rdc_req_type  req_data,
   output logic                  rsp_strobe,
   output rdc_pkg::rdc_rsp_type  rsp_data
);
   import rdc_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int unsigned IDX_W = $clog2(MAX_DIGITS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_READ   = 4'b0100,
      ST_EMIT   = 4'b1000
   } rdc_state_type;

   rdc_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff,   idx_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic               lower_ff, lower_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rdc_rsp_type        rsp_data_ff,   rsp_data_in;

   logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
   logic [DIGIT_W-1:0] rd_data_ff;
   logic               wr_en;

   logic               div_start;
   logic [VALUE_W-1:0] div_dividend;
   rdc_div_result_type div_res;

   rdc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (radix_ff),
      .result   (div_res)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      radix_in      = radix_ff;
      lower_in      = lower_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;
      div_dividend  = div_res.quotient;
      wr_en         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.radix < RADIX_MIN) begin
                  radix_in = RADIX_MIN;
               end else if (req_data.radix > RADIX_MAX) begin
                  radix_in = RADIX_MAX;
               end else begin
                  radix_in = req_data.radix;
               end
               lower_in     = req_data.lower_letters;
               count_in     = '0;
               div_start    = 1'b1;
               div_dividend = req_data.value;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_res.done) begin
               if (count_ff < CNT_W'(MAX_DIGITS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (div_res.quotient != '0) begin
                  div_start = 1'b1;
               end else begin
                  idx_in   = IDX_W'(count_in - 1'b1);
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_strobe_in          = 1'b1;
            rsp_data_in.digit_char = rdc_digit_char(rd_data_ff, lower_ff);
            rsp_data_in.last_digit = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      radix_ff    <= radix_in;
      lower_ff    <= lower_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_store[count_ff[IDX_W-1:0]] <= div_res.remainder;
      end
      rd_data_ff <= digit_store[idx_ff];
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `include "radix_digit_converter_defines.svh"

   `RDC_ASSERT_IMPLY(a_done_in_divide, clock, reset, div_res.done, state_ff == ST_DIVIDE)
   `RDC_ASSERT_IMPLY(a_count_bounded, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_DIGITS))
   `RDC_ASSERT_NEXT(a_last_ends_burst, clock, reset, rsp_strobe && rsp_data.last_digit, !rsp_strobe)
   `RDC_ASSERT_NEXT(a_strobe_after_emit, clock, reset, state_ff == ST_EMIT, rsp_strobe)

endmodule
